// ===== hdl/dfcw_pkg.sv =====
// Shared types, constants and helpers for the DAC frame change writer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dfcw_pkg;

  // Defaults for the top-level parameters.
  localparam int CHANNELS_DEF    = 8;
  localparam int TABLE_DEPTH_DEF = 4096;

  // Fixed field widths of the stream payloads.
  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_W     = 16;
  localparam int WORD_W       = 16;
  localparam int INDEX_W      = 12;
  localparam int CHAN_W       = 3;
  localparam int OP_W         = 2;

  // Input tdata layout: eight samples, then the table index and the table word.
  localparam int INDEX_LSB   = MAX_CHANNELS * SAMPLE_W;
  localparam int ENTRY_LSB   = INDEX_LSB + INDEX_W;
  localparam int S_TDATA_W   = ((ENTRY_LSB + WORD_W + 7) / 8) * 8;

  // Value that marks a cache entry as holding no sample.
  localparam logic [SAMPLE_W-1:0] INVALID_MARK = 16'hFFFF;

  // Base of the ramp that the correction table holds after reset.
  localparam logic [WORD_W-1:0] RAMP_BASE = 16'h1000;

  // Operation carried in the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_FRAME = 2'd0,
    OP_WRITE = 2'd1,
    OP_INVAL = 2'd2,
    OP_SPARE = 2'd3
  } op_t;

  // What one lane reports for the current frame.
  typedef struct packed {
    logic              changed;
    logic              use_table;
    logic [WORD_W-1:0] word;
  } lane_res_t;

  // Upper nibble of the command word: the DAC address of each channel.
  function automatic logic [3:0] addr_nibble(input int lane);
    logic [3:0] nib;
    case (lane)
      0:       nib = 4'h1;
      1:       nib = 4'h0;
      2:       nib = 4'h2;
      3:       nib = 4'h3;
      4:       nib = 4'h4;
      5:       nib = 4'h5;
      6:       nib = 4'h6;
      7:       nib = 4'h7;
      default: nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dfcw_lane.sv =====
// One channel lane: holds the cached sample, detects a change and forms the
// command word. Depends on dfcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfcw_lane #(
  parameter int LANE = 0
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             frame,
  input  wire logic                             invalidate,
  input  wire logic [dfcw_pkg::SAMPLE_W-1:0]    sample,
  output dfcw_pkg::lane_res_t                   res
);

  logic [dfcw_pkg::SAMPLE_W-1:0] prev;
  logic [dfcw_pkg::SAMPLE_W-1:0] prev_next;
  logic                          neg;
  logic [3:0]                    nib;

  assign neg = sample[dfcw_pkg::SAMPLE_W-1];
  assign nib = dfcw_pkg::addr_nibble(LANE);

  // Word formation differs between the corrected channel and the others.
  always_comb begin
    res.changed = (sample != prev);
    if (LANE == 0) begin
      // Positive samples are looked up in the table; negative ones send
      // the address with zero data. The cache keeps the raw sample.
      res.use_table = !neg;
      res.word      = {nib, 12'h000};
      prev_next     = sample;
    end else begin
      res.use_table = 1'b0;
      if (neg) begin
        res.word  = {nib, 12'h000};
        prev_next = '0;
      end else begin
        res.word  = {nib, sample[14:3]};
        prev_next = sample;
      end
    end
  end

  // Sample cache.
  always_ff @(posedge clk) begin
    if (rst || invalidate) begin
      prev <= dfcw_pkg::INVALID_MARK;
    end else if (frame && res.changed) begin
      prev <= prev_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dfcw_table.sv =====
// Correction table memory with a registered read port and a clearing pass
// that loads the reset ramp after reset. Depends on dfcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfcw_table #(
  parameter int DEPTH = dfcw_pkg::TABLE_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr_en,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic [dfcw_pkg::WORD_W-1:0]  wr_data,
  input  wire logic                         rd_en,
  input  wire logic [AW-1:0]                rd_addr,
  output logic      [dfcw_pkg::WORD_W-1:0]  rd_data,
  output logic                              ready
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [dfcw_pkg::WORD_W-1:0] mem [DEPTH];
  logic                        fill_busy;
  logic [AW-1:0]               fill_addr;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [dfcw_pkg::WORD_W-1:0] mem_wdata;

  assign ready = !fill_busy;

  // The clearing pass owns the write port until it is done.
  always_comb begin
    mem_we    = fill_busy || wr_en;
    mem_waddr = fill_busy ? fill_addr : wr_addr;
    mem_wdata = fill_busy ? (dfcw_pkg::RAMP_BASE + dfcw_pkg::WORD_W'(fill_addr)) : wr_data;
  end

  // Clearing pass sequencer, one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_busy <= 1'b1;
      fill_addr <= '0;
    end else if (fill_busy) begin
      fill_addr <= fill_addr + AW'(1);
      if (fill_addr == LAST_ADDR) begin
        fill_busy <= 1'b0;
      end
    end
  end

  // Storage: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dfcw_merge.sv =====
// Merging stage: holds one frame of lane results, then sends the changed
// channels out one command word per transfer in channel order, flagging the
// last. Depends on dfcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfcw_merge #(
  parameter int CHANNELS = dfcw_pkg::CHANNELS_DEF,
  localparam int SW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load,
  input  wire dfcw_pkg::lane_res_t [CHANNELS-1:0] lanes,
  input  wire logic [dfcw_pkg::WORD_W-1:0]       table_data,
  output logic                                   ready_in,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [dfcw_pkg::WORD_W-1:0]       out_word,
  output logic      [dfcw_pkg::CHAN_W-1:0]       out_chan,
  output logic                                   out_last
);

  // Frame stage, waiting for the table read to land.
  logic                              st_valid;
  logic [CHANNELS-1:0]               st_mask;
  logic                              st_use_table;
  logic [dfcw_pkg::WORD_W-1:0]       st_word [CHANNELS];

  // Serialiser.
  logic [CHANNELS-1:0]               ser_mask;
  logic [dfcw_pkg::WORD_W-1:0]       ser_word [CHANNELS];
  logic [SW-1:0]                     sel;
  logic [CHANNELS-1:0]               mask_rest;
  logic                              ser_busy;
  logic                              ser_free;
  logic                              emit;
  logic                              st_move;
  logic                              out_load;

  assign out_load = !out_valid || out_ready;
  assign ser_busy = |ser_mask;
  assign emit     = ser_busy && out_load;
  assign ser_free = !ser_busy || (emit && (mask_rest == '0));
  assign st_move  = st_valid && ser_free;
  assign ready_in = !st_valid || st_move;

  // Lowest pending channel goes next.
  always_comb begin
    sel = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (ser_mask[i]) begin
        sel = SW'(i);
      end
    end
    mask_rest      = ser_mask;
    mask_rest[sel] = 1'b0;
  end

  // Frame stage capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (load) begin
      st_valid <= 1'b1;
    end else if (st_move) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      st_use_table <= lanes[0].use_table;
      for (int i = 0; i < CHANNELS; i++) begin
        st_mask[i] <= lanes[i].changed;
        st_word[i] <= lanes[i].word;
      end
    end
  end

  // Serialiser mask and words; channel 0 takes the table word when needed.
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_mask <= '0;
    end else if (st_move) begin
      ser_mask <= st_mask;
    end else if (emit) begin
      ser_mask <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (st_move) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (i == 0 && st_use_table) begin
          ser_word[i] <= table_data;
        end else begin
          ser_word[i] <= st_word[i];
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= ser_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word <= ser_word[sel];
      out_chan <= dfcw_pkg::CHAN_W'(sel);
      out_last <= (mask_rest == '0);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dac_frame_change_writer_core.sv =====
// Top level of the DAC frame change writer: channel lanes, correction table
// and merging stage. Depends on dfcw_pkg, dfcw_lane, dfcw_table, dfcw_merge.
//
//   Stream   Dir  tdata                                      tuser      tlast
//   s_axis   in   sample_0..7, entry_index, entry_word       op         -
//   m_axis   out  dac_word                                   channel    last
//
// A sample frame is checked by all lanes in the cycle it is accepted; its
// command words, up to CHANNELS, then leave one per cycle while the output
// is not stalled. After reset the table is loaded with its ramp, one entry
// per cycle, so no transfer is accepted until all TABLE_DEPTH entries (4096
// by default) are loaded.
// A stalled output holds the merging stage; one further frame waits in the
// frame stage before s_axis_tready falls.
`timescale 1ns / 1ps
`default_nettype none

module dac_frame_change_writer_core #(
  parameter int CHANNELS    = dfcw_pkg::CHANNELS_DEF,
  parameter int TABLE_DEPTH = dfcw_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // sample_0 .. sample_7 (16 each), entry_index (12), entry_word (16), zero pad
  input  wire logic [dfcw_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // op (2)
  input  wire logic [dfcw_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // dac_word (16)
  output logic      [dfcw_pkg::WORD_W-1:0]       m_axis_tdata,
  // channel (3)
  output logic      [dfcw_pkg::CHAN_W-1:0]       m_axis_tuser,
  output logic                                   m_axis_tlast
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [dfcw_pkg::INDEX_W-1:0] TOP_INDEX = dfcw_pkg::INDEX_W'(TABLE_DEPTH - 1);

  logic                                     accept;
  logic                                     frame;
  logic                                     invalidate;
  logic                                     tab_write;
  logic                                     tab_ready;
  logic                                     merge_ready;
  logic [dfcw_pkg::INDEX_W-1:0]             entry_index;
  logic [dfcw_pkg::WORD_W-1:0]              entry_word;
  logic [dfcw_pkg::INDEX_W-1:0]             rd_index;
  logic [dfcw_pkg::WORD_W-1:0]              table_data;
  dfcw_pkg::op_t                            op;
  dfcw_pkg::lane_res_t [CHANNELS-1:0]       lanes;

  // Input decode.
  assign op            = dfcw_pkg::op_t'(s_axis_tuser);
  assign s_axis_tready = tab_ready && merge_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign frame         = accept && (op == dfcw_pkg::OP_FRAME);
  assign invalidate    = accept && (op == dfcw_pkg::OP_INVAL);
  assign entry_index   = s_axis_tdata[dfcw_pkg::INDEX_LSB +: dfcw_pkg::INDEX_W];
  assign entry_word    = s_axis_tdata[dfcw_pkg::ENTRY_LSB +: dfcw_pkg::WORD_W];
  assign tab_write     = accept && (op == dfcw_pkg::OP_WRITE) && (entry_index <= TOP_INDEX);

  // Channel 0 table address, saturated at the last entry.
  always_comb begin
    rd_index = s_axis_tdata[14:3];
    if (rd_index > TOP_INDEX) begin
      rd_index = TOP_INDEX;
    end
  end

  // Lanes, one per channel.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    dfcw_lane #(
      .LANE (c)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .frame      (frame),
      .invalidate (invalidate),
      .sample     (s_axis_tdata[c*dfcw_pkg::SAMPLE_W +: dfcw_pkg::SAMPLE_W]),
      .res        (lanes[c])
    );
  end

  // Correction table.
  dfcw_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tab_write),
    .wr_addr (AW'(entry_index)),
    .wr_data (entry_word),
    .rd_en   (frame),
    .rd_addr (AW'(rd_index)),
    .rd_data (table_data),
    .ready   (tab_ready)
  );

  // Merging stage and output register.
  dfcw_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (frame),
    .lanes      (lanes),
    .table_data (table_data),
    .ready_in   (merge_ready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_word   (m_axis_tdata),
    .out_chan   (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

endmodule

`default_nettype wire
